[sv/rwl_pkg.sv]
// Shared types, constants and codes for the round-trip window latency latch.
`default_nettype none
package rwl_pkg;

  localparam int unsigned WINDOW_DEF      = 32;
  localparam int unsigned MIN_SAMPLES_DEF = 12;
  localparam int unsigned MAX_DELAY_DEF   = 15;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned GEN_W   = 32;
  localparam int unsigned DWELL_W = 32;
  localparam int unsigned RTT_W   = 21;
  localparam int unsigned DLY_W   = 4;
  localparam int unsigned FP_W    = 20;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned ACC_W   = 25;

  localparam int unsigned IN_W    = 168;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [TIME_W-1:0] MAX_RTT_US     = 48'd2000000;
  localparam logic [TIME_W-1:0] STALL_FLOOR_US = 48'd50000;
  localparam logic [TIME_W-1:0] RISE_GAP_US    = 48'd150000;
  localparam logic [TIME_W-1:0] DECAY_GAP_US   = 48'd300000;
  localparam int unsigned       STALL_MIN_COUNT = 4;
  localparam logic [FP_W-1:0]   FP_RESET       = 20'd16667;
  localparam logic [DLY_W-1:0]  DIV_CAP        = 4'd15;

  localparam logic [CFG_IDX_W-1:0] REG_PROBE_ENABLE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_FLOOR    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_DELAY = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD   = 8'd3;

  typedef enum logic [STAT_W-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_DISABLED = 3'd1,
    ST_STALE    = 3'd2,
    ST_CLOCK    = 3'd3,
    ST_TOO_LONG = 3'd4,
    ST_STALL    = 3'd5,
    ST_DELAY    = 3'd6,
    ST_RESET    = 3'd7
  } status_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ACK   = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_RESET = 2'd2,
    MODE_SPARE = 2'd3
  } mode_t;

  typedef struct packed {
    logic             probe_enable;
    logic [DLY_W-1:0] delay_floor;
    logic [DLY_W-1:0] fallback_delay;
    logic [FP_W-1:0]  frame_len_us;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_ACK_SUB, S_ACK_CHK, S_STALL_RD, S_STALL_CK,
    S_OLD_RD, S_OLD_CAP, S_DEL_RD, S_DEL_CK, S_INS_RD, S_INS_CK,
    S_INS_BOT, S_INS_END, S_Q_RD, S_Q_CAP, S_DIV, S_LATCH,
    S_FIN_MED, S_FIN_P95, S_FIN_CAP, S_DONE
  } state_t;

endpackage
`default_nettype wire

[sv/rwl_ram.sv]
// Simple memory: one write port, one read port with registered read data.
`default_nettype none
module rwl_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned W     = 21,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/rwl_core.sv]
// Sequencer and shared datapath: sample checks, sorted-window upkeep, target and latch.
`default_nettype none
module rwl_core
  import rwl_pkg::*;
#(
  parameter int unsigned WINDOW      = WINDOW_DEF,
  parameter int unsigned MIN_SAMPLES = MIN_SAMPLES_DEF,
  parameter int unsigned MAX_DELAY   = MAX_DELAY_DEF,
  localparam int unsigned IDX_W      = $clog2(WINDOW),
  localparam int unsigned CNT_W      = $clog2(WINDOW + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [MODE_W-1:0]  in_mode,
  input  wire logic [TIME_W-1:0]  in_now,
  input  wire logic [GEN_W-1:0]   in_gen,
  input  wire logic [TIME_W-1:0]  in_stamp,
  input  wire logic [DWELL_W-1:0] in_dwell,
  output logic                    res_valid,
  input  wire logic               res_take,
  output logic [STAT_W-1:0]       res_status,
  output logic [DLY_W-1:0]        res_delay,
  output logic [RTT_W-1:0]        res_median,
  output logic [RTT_W-1:0]        res_p95,
  output logic [CNT_W-1:0]        res_count,
  output logic [GEN_W-1:0]        res_gen
);

  localparam logic [CNT_W-1:0] WIN_C   = CNT_W'(WINDOW);
  localparam logic [CNT_W-1:0] MIN_C   = CNT_W'(MIN_SAMPLES);
  localparam logic [CNT_W-1:0] STALL_C = CNT_W'(STALL_MIN_COUNT);
  localparam logic [IDX_W:0]   LAST_I  = (IDX_W+1)'(WINDOW - 1);
  localparam logic [4:0]       MAXD_C  = 5'(MAX_DELAY);

  state_t state_r, state_nxt;

  logic [MODE_W-1:0]  mode_r;
  logic [TIME_W-1:0]  now_r, stamp_r, rtt_r, rise_r, decay_r;
  logic [GEN_W-1:0]   agen_r, gen_r;
  logic [DWELL_W-1:0] dwell_r;
  logic [STAT_W-1:0]  status_r;
  logic [DLY_W-1:0]   delay_r, lval_r;
  logic               lvalid_r, found_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   head_r;
  logic [IDX_W:0]     idx_r;
  logic [RTT_W-1:0]   old_r, p95q_r, med_o_r, p95_o_r;
  logic [DLY_W-1:0]   k_r;
  logic [ACC_W-1:0]   acc_r;

  // memory ports
  logic               srt_we, ring_we;
  logic [IDX_W-1:0]   srt_waddr, srt_raddr, ring_raddr;
  logic [RTT_W-1:0]   srt_wdata, srt_rdata, ring_rdata;

  rwl_ram #(.DEPTH(WINDOW), .W(RTT_W)) u_sorted (
    .clk(clk), .we(srt_we), .waddr(srt_waddr), .wdata(srt_wdata),
    .raddr(srt_raddr), .rdata(srt_rdata)
  );

  rwl_ram #(.DEPTH(WINDOW), .W(RTT_W)) u_ring (
    .clk(clk), .we(ring_we), .waddr(head_r), .wdata(rtt_r[RTT_W-1:0]),
    .raddr(ring_raddr), .rdata(ring_rdata)
  );

  // percentile positions of the current window
  logic [CNT_W-1:0] cm1;
  logic [31:0]      y19, q95;
  logic [IDX_W-1:0] med_idx, p95_idx;

  always_comb begin
    cm1     = cnt_r - CNT_W'(1);
    y19     = 32'(cm1) * 32'd19;
    q95     = (y19 * 32'd3277) >> 16;
    med_idx = IDX_W'(cm1 >> 1);
    p95_idx = q95[IDX_W-1:0];
  end

  logic [RTT_W-1:0] rtt_v;
  assign rtt_v = rtt_r[RTT_W-1:0];

  // target and latch step
  logic [ACC_W-1:0] two_f;
  logic [24:0]      twelve_f;
  logic             big;
  logic [4:0]       tgt, newl;
  logic [TIME_W-1:0] el_rise, el_decay;
  logic             set_rise, set_decay;
  logic [DLY_W-1:0] fb_max;

  always_comb begin
    two_f    = ACC_W'({cfg.frame_len_us, 1'b0});
    twelve_f = 25'({cfg.frame_len_us, 3'b0}) + 25'({cfg.frame_len_us, 2'b0});
    big      = (cfg.frame_len_us != '0) && (25'(p95q_r) >= twelve_f);
    tgt      = 5'(k_r) + 5'd1 + 5'(big);
    if (tgt < 5'(cfg.delay_floor)) tgt = 5'(cfg.delay_floor);
    if (tgt > MAXD_C) tgt = MAXD_C;
    el_rise  = now_r - rise_r;
    el_decay = now_r - decay_r;
    newl      = 5'(lval_r);
    set_rise  = 1'b0;
    set_decay = 1'b0;
    if (!lvalid_r) begin
      newl = tgt;
      set_rise = 1'b1;
      set_decay = 1'b1;
    end else if (tgt > 5'(lval_r)) begin
      if (el_rise >= RISE_GAP_US) begin
        newl = 5'(lval_r) + 5'd1;
        set_rise = 1'b1;
        set_decay = 1'b1;
      end
    end else if (tgt < 5'(lval_r)) begin
      if (el_decay >= DECAY_GAP_US) begin
        if (lval_r != '0) newl = 5'(lval_r) - 5'd1;
        set_decay = 1'b1;
      end
    end else begin
      set_rise = 1'b1;
      set_decay = 1'b1;
    end
    if (newl < 5'(cfg.delay_floor)) newl = 5'(cfg.delay_floor);
    if (newl > MAXD_C) newl = MAXD_C;
    fb_max = (cfg.fallback_delay > cfg.delay_floor) ? cfg.fallback_delay : cfg.delay_floor;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        case (mode_r)
          MODE_RESET: state_nxt = S_FIN_MED;
          MODE_ACK: begin
            if (!cfg.probe_enable || agen_r != gen_r || stamp_r > now_r) begin
              state_nxt = S_FIN_MED;
            end else begin
              state_nxt = S_ACK_SUB;
            end
          end
          default: state_nxt = (cnt_r < MIN_C) ? S_FIN_MED : S_Q_RD;
        endcase
      end
      S_ACK_SUB:  state_nxt = S_ACK_CHK;
      S_ACK_CHK: begin
        if (rtt_r > MAX_RTT_US) state_nxt = S_FIN_MED;
        else if (cnt_r >= STALL_C) state_nxt = S_STALL_RD;
        else state_nxt = S_OLD_RD;
      end
      S_STALL_RD: state_nxt = S_STALL_CK;
      S_STALL_CK: begin
        if (srt_rdata != '0 && rtt_r > TIME_W'({srt_rdata, 2'b0}) &&
            rtt_r > STALL_FLOOR_US) begin
          state_nxt = S_FIN_MED;
        end else begin
          state_nxt = S_OLD_RD;
        end
      end
      S_OLD_RD: state_nxt = S_OLD_CAP;
      S_OLD_CAP: begin
        if (cnt_r == WIN_C) state_nxt = S_DEL_RD;
        else if (cnt_r == '0) state_nxt = S_INS_BOT;
        else state_nxt = S_INS_RD;
      end
      S_DEL_RD:  state_nxt = S_DEL_CK;
      S_DEL_CK:  state_nxt = (idx_r == LAST_I) ? S_INS_RD : S_DEL_RD;
      S_INS_RD:  state_nxt = S_INS_CK;
      S_INS_CK: begin
        if (srt_rdata > rtt_v) state_nxt = (idx_r == '0) ? S_INS_BOT : S_INS_RD;
        else state_nxt = S_INS_END;
      end
      S_INS_BOT: state_nxt = S_INS_END;
      S_INS_END: state_nxt = S_FIN_MED;
      S_Q_RD:    state_nxt = S_Q_CAP;
      S_Q_CAP:   state_nxt = S_DIV;
      S_DIV: begin
        if (cfg.frame_len_us == '0 || acc_r >= ACC_W'(p95q_r) || k_r == DIV_CAP) begin
          state_nxt = S_LATCH;
        end
      end
      S_LATCH:   state_nxt = S_FIN_MED;
      S_FIN_MED: state_nxt = S_FIN_P95;
      S_FIN_P95: state_nxt = S_FIN_CAP;
      S_FIN_CAP: state_nxt = S_DONE;
      S_DONE:    if (res_take) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // memory control and handshake outputs
  always_comb begin
    srt_we     = 1'b0;
    srt_waddr  = '0;
    srt_wdata  = rtt_v;
    srt_raddr  = '0;
    ring_we    = 1'b0;
    ring_raddr = head_r;
    in_ready   = (state_r == S_IDLE);
    res_valid  = (state_r == S_DONE);
    case (state_r)
      S_STALL_RD: srt_raddr = med_idx;
      S_OLD_CAP:  ring_we = 1'b1;
      S_DEL_RD,
      S_INS_RD:   srt_raddr = idx_r[IDX_W-1:0];
      S_DEL_CK: begin
        srt_we    = found_r;
        srt_waddr = IDX_W'(idx_r - 1'b1);
        srt_wdata = srt_rdata;
      end
      S_INS_CK: begin
        srt_we    = 1'b1;
        srt_waddr = IDX_W'(idx_r + 1'b1);
        srt_wdata = (srt_rdata > rtt_v) ? srt_rdata : rtt_v;
      end
      S_INS_BOT:  srt_we = 1'b1;
      S_Q_RD:     srt_raddr = p95_idx;
      S_FIN_MED:  srt_raddr = med_idx;
      S_FIN_P95:  srt_raddr = p95_idx;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      gen_r    <= GEN_W'(1);
      cnt_r    <= '0;
      head_r   <= '0;
      lvalid_r <= 1'b0;
      lval_r   <= '0;
      rise_r   <= '0;
      decay_r  <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          mode_r  <= in_mode;
          now_r   <= in_now;
          agen_r  <= in_gen;
          stamp_r <= in_stamp;
          dwell_r <= in_dwell;
        end
        S_DECODE: begin
          delay_r <= '0;
          rtt_r   <= now_r - stamp_r;
          case (mode_r)
            MODE_RESET: begin
              gen_r    <= gen_r + GEN_W'(1);
              cnt_r    <= '0;
              head_r   <= '0;
              lvalid_r <= 1'b0;
              lval_r   <= '0;
              rise_r   <= '0;
              decay_r  <= '0;
              status_r <= ST_RESET;
            end
            MODE_ACK: begin
              if (!cfg.probe_enable) status_r <= ST_DISABLED;
              else if (agen_r != gen_r) status_r <= ST_STALE;
              else status_r <= ST_CLOCK;
            end
            default: begin
              status_r <= ST_DELAY;
              delay_r  <= lvalid_r ? lval_r : fb_max;
            end
          endcase
        end
        S_ACK_SUB: if (TIME_W'(dwell_r) < rtt_r) rtt_r <= rtt_r - TIME_W'(dwell_r);
        S_ACK_CHK: status_r <= ST_TOO_LONG;
        S_STALL_CK: status_r <= ST_STALL;
        S_OLD_CAP: begin
          old_r   <= ring_rdata;
          found_r <= 1'b0;
          idx_r   <= (cnt_r == WIN_C) ? '0 : (IDX_W+1)'(cnt_r - CNT_W'(1));
        end
        S_DEL_CK: begin
          if (!found_r && srt_rdata == old_r) found_r <= 1'b1;
          idx_r <= (idx_r == LAST_I) ? (IDX_W+1)'(WINDOW - 2) : idx_r + 1'b1;
        end
        S_INS_CK: idx_r <= idx_r - 1'b1;
        S_INS_END: begin
          status_r <= ST_ACCEPTED;
          head_r   <= (32'(head_r) == WINDOW - 1) ? '0 : head_r + 1'b1;
          if (cnt_r < WIN_C) cnt_r <= cnt_r + CNT_W'(1);
        end
        S_Q_CAP: begin
          p95q_r <= srt_rdata;
          k_r    <= '0;
          acc_r  <= '0;
        end
        S_DIV: begin
          if (state_nxt == S_DIV) begin
            k_r   <= k_r + 1'b1;
            acc_r <= acc_r + two_f;
          end
        end
        S_LATCH: begin
          lvalid_r <= 1'b1;
          lval_r   <= newl[DLY_W-1:0];
          delay_r  <= newl[DLY_W-1:0];
          if (set_rise) rise_r <= now_r;
          if (set_decay) decay_r <= now_r;
        end
        S_FIN_P95: med_o_r <= (cnt_r == '0) ? '0 : srt_rdata;
        S_FIN_CAP: p95_o_r <= (cnt_r == '0) ? '0 : srt_rdata;
        default: ;
      endcase
    end
  end

  assign res_status = status_r;
  assign res_delay  = delay_r;
  assign res_median = med_o_r;
  assign res_p95    = p95_o_r;
  assign res_count  = cnt_r;
  assign res_gen    = gen_r;

endmodule
`default_nettype wire

[sv/rtt_window_latency_latch.sv]
// Top level: configuration registers, core sequencer and the result register.
// A query with a full measurement walks the frame-count loop, and an accepted
//   sample walks the sorted window once or twice, with a read and a check per entry.
// Throughput: one item at a time; the next item is taken the cycle after the
//   result enters the output register. Reset (rst_n low, synchronous) empties the
//   window, sets the generation to one and loads register reset values; no clearing pass.
`default_nettype none
module rtt_window_latency_latch
  import rwl_pkg::*;
#(
  parameter int unsigned WINDOW      = WINDOW_DEF,
  parameter int unsigned MIN_SAMPLES = MIN_SAMPLES_DEF,
  parameter int unsigned MAX_DELAY   = MAX_DELAY_DEF,
  localparam int unsigned CNT_W      = $clog2(WINDOW + 1),
  localparam int unsigned OUT_BITS   = 103 + CNT_W,
  localparam int unsigned OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // mode, now_us, ack_generation, ack_stamp_us, ack_dwell_us (lowest bit up)
  input  wire logic [IN_W-1:0]       in_tdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // status, latched_delay_out, rtt_median, p95_us, jitter_us, samples_held,
  // has_measurement, current_generation (lowest bit up)
  output logic [OUT_W-1:0]           out_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;

  // registers take writes at any time; software must write only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.probe_enable    <= 1'b0;
      cfg_r.delay_floor     <= '0;
      cfg_r.fallback_delay  <= '0;
      cfg_r.frame_len_us    <= FP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROBE_ENABLE:   cfg_r.probe_enable    <= cfg_data[0];
        REG_DELAY_FLOOR:    cfg_r.delay_floor     <= cfg_data[DLY_W-1:0];
        REG_FALLBACK_DELAY: cfg_r.fallback_delay  <= cfg_data[DLY_W-1:0];
        REG_FRAME_PERIOD:   cfg_r.frame_len_us    <= cfg_data[FP_W-1:0];
        default: ;
      endcase
    end
  end

  logic               res_valid, res_take;
  logic [STAT_W-1:0]  res_status;
  logic [DLY_W-1:0]   res_delay;
  logic [RTT_W-1:0]   res_median, res_p95, jitter;
  logic [CNT_W-1:0]   res_count;
  logic [GEN_W-1:0]   res_gen;

  rwl_core #(
    .WINDOW(WINDOW), .MIN_SAMPLES(MIN_SAMPLES), .MAX_DELAY(MAX_DELAY)
  ) u_core (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_mode(in_tdata[1:0]),
    .in_now(in_tdata[49:2]),
    .in_gen(in_tdata[81:50]),
    .in_stamp(in_tdata[129:82]),
    .in_dwell(in_tdata[161:130]),
    .res_valid(res_valid), .res_take(res_take),
    .res_status(res_status), .res_delay(res_delay),
    .res_median(res_median), .res_p95(res_p95),
    .res_count(res_count), .res_gen(res_gen)
  );

  // jitter saturates at zero
  assign jitter = (res_p95 > res_median) ? res_p95 - res_median : '0;

  // load the result register when it is empty or being drained
  assign res_take = !out_tvalid || out_tready;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_data_r <= OUT_W'({res_gen, (res_count >= CNT_W'(MIN_SAMPLES)), res_count,
                            jitter, res_p95, res_median, res_delay, res_status});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

[sv/rwl_checker.sv]
// Port-level checker for the round-trip window latency latch, bound to the top.
`default_nettype none
module rwl_checker
  import rwl_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [111:0] out_tdata,
  input wire logic         out_tvalid,
  input wire logic         out_tready
);

  // hold a stalled result steady
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item at a time: drop ready right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready held after accept");

  // a session reset result shows an empty window
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == ST_RESET |-> out_tdata[75:70] == 6'd0 &&
      out_tdata[76] == 1'b0 && out_tdata[27:7] == 21'd0)
    else $error("reset result shows samples");

  // an accepted sample leaves at least one sample held
  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == ST_ACCEPTED |-> out_tdata[75:70] != 6'd0)
    else $error("accepted sample but window empty");

endmodule

bind rtt_window_latency_latch rwl_checker u_rwl_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready)
);
`default_nettype wire

[test/testbench.sv]
// Testbench for the round-trip window latency latch: a predictor, stimulus and result checks.
`timescale 1ns / 100ps
module testbench;
  import rwl_pkg::*;

  localparam int unsigned OUT_W = 112;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  // mode, now_us, ack_generation, ack_stamp_us, ack_dwell_us (lowest bit up)
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // status, latched_delay_out, rtt_median, p95_us, jitter_us, samples_held,
  // has_measurement, current_generation (lowest bit up)
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rtt_window_latency_latch dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  typedef struct {
    status_t     status;
    bit [3:0]    delay;
    bit [20:0]   median;
    bit [20:0]   p95;
    bit [20:0]   jitter;
    bit [5:0]    held;
    bit          has_meas;
    bit [31:0]   generation;
  } window_report_t;

  window_report_t pending_reports[$];
  int unsigned    mismatches = 0;
  bit             calm = 1'b0;       // no idling on either side when set
  int unsigned    hold_ticket = 0;   // bump to make the receiver hold off

  // Mirror of the block: sample window, latch and registers
  bit [20:0] win_rtt [32];
  int unsigned win_count, win_head;
  bit [31:0] gen_now;
  bit        latch_ok;
  bit [3:0]  latch_frames;
  bit [47:0] rise_stamp, decay_stamp;
  bit        reg_enable;
  bit [3:0]  reg_floor, reg_fallback;
  bit [19:0] reg_frame_us;

  // Walk of the tracked stream time
  bit [47:0] clock_us;

  function automatic bit [20:0] window_rank(int unsigned permille);
    bit [20:0] sorted [32];
    bit [20:0] v;
    int unsigned i, j, idx;
    if (win_count == 0) return '0;
    for (i = 0; i < win_count; i++) begin
      v = win_rtt[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    idx = ((win_count - 1) * permille) / 1000;
    return sorted[idx];
  endfunction

  function automatic bit [3:0] clamp_frames(longint unsigned d);
    if (d < reg_floor) d = reg_floor;
    if (d > MAX_DELAY_DEF) d = MAX_DELAY_DEF;
    return d[3:0];
  endfunction

  function automatic status_t screen_ack(bit [47:0] now, bit [31:0] g, bit [47:0] stamp,
                                         bit [31:0] dwell);
    longint unsigned rtt, med;
    if (!reg_enable) return ST_DISABLED;
    if (g != gen_now) return ST_STALE;
    if (stamp > now) return ST_CLOCK;
    rtt = now - stamp;
    if (dwell < rtt) rtt -= dwell;
    if (rtt > 2000000) return ST_TOO_LONG;
    if (win_count >= STALL_MIN_COUNT) begin
      med = window_rank(500);
      if (med > 0 && rtt > med * 4 && rtt > 50000) return ST_STALL;
    end
    win_rtt[win_head] = rtt[20:0];
    win_head = (win_head + 1) % 32;
    if (win_count < 32) win_count++;
    return ST_ACCEPTED;
  endfunction

  function automatic bit [3:0] update_latch(bit [47:0] now);
    longint unsigned p95, frames, two_f, tgt;
    bit [47:0] elapsed;
    if (win_count < MIN_SAMPLES_DEF) begin
      if (latch_ok) return latch_frames;
      return (reg_fallback > reg_floor) ? reg_fallback : reg_floor;
    end
    p95 = window_rank(950);
    frames = 0;
    tgt = 1;
    if (reg_frame_us != 0) begin
      two_f = 2 * reg_frame_us;
      frames = (p95 + two_f - 1) / two_f;
      tgt = frames + 1 + ((p95 >= 12 * longint'(reg_frame_us)) ? 1 : 0);
    end
    tgt = clamp_frames(tgt);
    if (!latch_ok) begin
      latch_ok = 1'b1;
      latch_frames = tgt[3:0];
      rise_stamp = now;
      decay_stamp = now;
      return latch_frames;
    end
    if (tgt > latch_frames) begin
      elapsed = now - rise_stamp;
      if (elapsed >= RISE_GAP_US) begin
        latch_frames++;
        rise_stamp = now;
        decay_stamp = now;
      end
    end else if (tgt < latch_frames) begin
      elapsed = now - decay_stamp;
      if (elapsed >= DECAY_GAP_US) begin
        if (latch_frames > 0) latch_frames--;
        decay_stamp = now;
      end
    end else begin
      rise_stamp = now;
      decay_stamp = now;
    end
    latch_frames = clamp_frames(latch_frames);
    return latch_frames;
  endfunction

  function automatic window_report_t predict_report(mode_t m, bit [47:0] now, bit [31:0] g,
                                                    bit [47:0] stamp, bit [31:0] dwell);
    window_report_t r;
    r.delay = '0;
    case (m)
      MODE_ACK: r.status = screen_ack(now, g, stamp, dwell);
      MODE_RESET: begin
        gen_now++;
        win_count = 0;
        win_head = 0;
        latch_ok = 1'b0;
        latch_frames = '0;
        rise_stamp = '0;
        decay_stamp = '0;
        r.status = ST_RESET;
      end
      default: begin
        r.delay = update_latch(now);
        r.status = ST_DELAY;
      end
    endcase
    r.median = window_rank(500);
    r.p95 = window_rank(950);
    r.jitter = (r.p95 > r.median) ? r.p95 - r.median : '0;
    r.held = win_count[5:0];
    r.has_meas = (win_count >= MIN_SAMPLES_DEF);
    r.generation = gen_now;
    return r;
  endfunction

  // Offer one item; hold valid high across back-to-back items
  task automatic send_item(mode_t m, bit [47:0] now, bit [31:0] g, bit [47:0] stamp,
                           bit [31:0] dwell);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tdata  <= {6'b0, dwell, stamp, g, now, m};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_reports.push_back(predict_report(m, now, g, stamp, dwell));
  endtask

  // Drop valid and wait for every result to drain
  task automatic drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PROBE_ENABLE:   reg_enable = val[0];
      REG_DELAY_FLOOR:    reg_floor = val[3:0];
      REG_FALLBACK_DELAY: reg_fallback = val[3:0];
      REG_FRAME_PERIOD:   reg_frame_us = val[19:0];
      default: ;
    endcase
  endtask

  task automatic set_config(bit en, bit [3:0] fl, bit [3:0] fb, bit [19:0] fp);
    write_reg(REG_PROBE_ENABLE, en);
    write_reg(REG_DELAY_FLOOR, fl);
    write_reg(REG_FALLBACK_DELAY, fb);
    write_reg(REG_FRAME_PERIOD, fp);
  endtask

  // Well-formed acknowledgment carrying the current generation
  task automatic send_ack(longint unsigned rtt, bit [31:0] dwell);
    clock_us += $urandom_range(500, 40000);
    send_item(MODE_ACK, clock_us, gen_now, clock_us - rtt[47:0], dwell);
  endtask

  task automatic send_query(int unsigned step_us);
    clock_us += step_us;
    send_item(MODE_QUERY, clock_us, '0, '0, '0);
  endtask

  // Receiver: check each result and pace out_tready
  int unsigned stall_left = 0, hold_left = 0, ticket_seen = 0;
  always @(posedge clk) begin
    if (out_tvalid && out_tready) check_report(out_tdata);
    if (hold_ticket != ticket_seen) begin
      ticket_seen <= hold_ticket;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!rst_n || calm) begin
      out_tready <= rst_n;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic check_report(logic [OUT_W-1:0] d);
    window_report_t w;
    if (pending_reports.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected item, expected none, actual %h", $time, d);
      return;
    end
    w = pending_reports.pop_front();
    compare_field("status", w.status, d[2:0]);
    compare_field("latched_delay", w.delay, d[6:3]);
    compare_field("median", w.median, d[27:7]);
    compare_field("p95_us", w.p95, d[48:28]);
    compare_field("jitter_us", w.jitter, d[69:49]);
    compare_field("samples_held", w.held, d[75:70]);
    compare_field("has_measurement", w.has_meas, d[76]);
    compare_field("generation", w.generation, d[108:77]);
  endtask

  // Queries before any measurement, a disabled ack, the spare mode
  task automatic test_idle_queries;
    send_query(1000);
    send_item(MODE_ACK, 48'hFFFF_FFFF_FFFF, gen_now, '0, '0);
    drain();
    set_config(1'b1, 4'd3, 4'd9, 20'd16667);
    send_query(1000);
    send_item(MODE_SPARE, clock_us, '0, '0, '0);
    drain();
    set_config(1'b1, 4'd12, 4'd2, 20'd16667);
    send_query(1000);
    drain();
  endtask

  // Generation, clock order, length and stall screens, then a session reset
  task automatic test_ack_screens;
    send_item(MODE_ACK, clock_us, 32'h0, clock_us - 100, '0);
    send_item(MODE_ACK, clock_us, 32'hFFFF_FFFF, clock_us - 100, '0);
    send_item(MODE_ACK, clock_us, gen_now, clock_us + 1, '0);
    send_ack(2000001, 0);
    send_ack(2000000, 32'hFFFF_FFFF);
    send_ack(30000, 32'hFFFF_FFFF);
    send_ack(30000, 10000);
    send_ack(20000, 0);
    send_ack(20000, 0);
    send_ack(1500000, 0);
    send_ack(2100000, 200000);
    send_item(MODE_RESET, clock_us, '0, '0, '0);
    drain();
  endtask

  // Fill the window, latch the first target, then push it up and down
  task automatic test_latch_moves;
    set_config(1'b1, 4'd0, 4'd5, 20'd16667);
    repeat (12) send_ack($urandom_range(15000, 25000), 0);
    send_query(1000);
    repeat (12) send_ack($urandom_range(150000, 190000), 0);
    send_query(100000);
    send_query(160000);
    send_query(160000);
    repeat (20) send_ack($urandom_range(1000, 3000), 0);
    send_query(200000);
    send_query(310000);
    drain();
  endtask

  // Random phases under changing settings, mostly well-formed traffic
  task automatic test_random_traffic;
    int unsigned phase, n, pick;
    longint unsigned rtt;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(1'b1, 4'd0, 4'd15, 20'd1);
        1: set_config(1'b1, 4'd15, 4'd0, 20'd1000000);
        2: set_config(1'b0, 4'($urandom), 4'($urandom), 20'($urandom_range(1, 1000000)));
        5: set_config(1'b1, 4'd0, 4'd0, 20'd16667);
        default: set_config(1'b1, 4'($urandom_range(0, 6)), 4'($urandom),
                            20'($urandom_range(2000, 40000)));
      endcase
      if (phase == 3) clock_us = 48'hFFFF_FFF0_0000;
      else if (phase == 4) clock_us = 48'({$urandom, $urandom}) & 48'h7FFF_FFFF_FFFF;
      calm = (phase == 5);
      for (n = 0; n < 100; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
          case ($urandom_range(0, 9))
            0: rtt = $urandom_range(200000, 1900000);
            1: rtt = $urandom_range(1900000, 2200000);
            2: rtt = $urandom_range(0, 200);
            default: rtt = $urandom_range(2000, 90000);
          endcase
          send_ack(rtt, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000));
        end else if (pick < 84) begin
          send_query($urandom_range(10000, 400000));
        end else if (pick < 87) begin
          send_item(MODE_RESET, clock_us, $urandom, 48'($urandom), $urandom);
        end else begin
          send_item(mode_t'($urandom_range(0, 3)), 48'({$urandom, $urandom}),
                    $urandom, 48'({$urandom, $urandom}), $urandom);
        end
      end
      drain();
    end
  endtask

  // Hold the receiver off while items keep coming, so the input stalls
  task automatic test_output_hold;
    calm = 1'b1;
    hold_ticket <= hold_ticket + 1;
    repeat (20) begin
      if ($urandom_range(0, 1) == 0) send_query($urandom_range(10000, 200000));
      else send_ack($urandom_range(5000, 40000), 0);
    end
    drain();
  endtask

  initial begin
    gen_now = 32'd1;
    win_count = 0;
    win_head = 0;
    latch_ok = 1'b0;
    latch_frames = '0;
    rise_stamp = '0;
    decay_stamp = '0;
    reg_enable = 1'b0;
    reg_floor = '0;
    reg_fallback = '0;
    reg_frame_us = FP_RESET;
    clock_us = 48'd5000000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_queries();
    test_ack_screens();
    test_latch_moves();
    test_random_traffic();
    test_output_hold();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end

endmodule
